/* rtl/heightmap_minmax_color_stretch_macros.svh */
// ----------------------------------------------------------------------------
// heightmap_minmax_color_stretch assertion macros
// shorthand for clocked implication checks, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_MINMAX_COLOR_STRETCH_MACROS_SVH
`define HEIGHTMAP_MINMAX_COLOR_STRETCH_MACROS_SVH

// same-cycle implication
`define HMCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HMCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hmcs_pkg.sv */
// ----------------------------------------------------------------------------
// hmcs_pkg
// shared constants, codes and status types of the height map color stretch
// ----------------------------------------------------------------------------
`default_nettype none

package hmcs_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS  = 1'b1;

    localparam logic [CFG_W-1:0] MAP_WIDTH_RST = 11'd64;
    localparam logic [CFG_W-1:0] MAP_ROWS_RST  = 11'd64;

    // request codes
    localparam logic REQ_SCAN    = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // color levels
    localparam int RED_W   = 8;
    localparam int GREEN_W = 7;

    // front to back job queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] level;
    } hmcs_queue_status_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } hmcs_back_status_t;

endpackage

`default_nettype wire

/* rtl/hmcs_if.sv */
// ----------------------------------------------------------------------------
// hmcs_if
// valid/ready channels for height samples in and colored vertices out
// ----------------------------------------------------------------------------
`default_nettype none

interface hmcs_in_if #(
    parameter int HEIGHT_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [HEIGHT_BITS-1:0] height_sample;

    modport source (output valid, output req_type, output height_sample, input ready);
    modport sink   (input valid, input req_type, input height_sample, output ready);
endinterface

interface hmcs_out_if #(
    parameter int HEIGHT_BITS = 16,
    parameter int COORD_W     = 10
);
    logic                          valid;
    logic                          ready;
    logic [COORD_W-1:0]            vert_x;
    logic [COORD_W-1:0]            vert_y;
    logic signed [HEIGHT_BITS-1:0] vert_height;
    logic [7:0]                    red_level;
    logic [6:0]                    green_level;
    logic                          flat_error;
    logic                          frame_last;

    modport source (
        output valid, output vert_x, output vert_y, output vert_height,
        output red_level, output green_level, output flat_error, output frame_last,
        input ready
    );
    modport sink (
        input valid, input vert_x, input vert_y, input vert_height,
        input red_level, input green_level, input flat_error, input frame_last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/hmcs_front.sv */
// ----------------------------------------------------------------------------
// hmcs_front
// accepts samples, tracks min/max on scans, turns converts into divide jobs
// ----------------------------------------------------------------------------
`default_nettype none

module hmcs_front #(
    parameter int MAX_DIM     = 1024,
    parameter int HEIGHT_BITS = 16,
    parameter int CW          = 10,
    parameter int JOB_W       = 2 * 10 + 3 * 16 + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hmcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hmcs_pkg::CFG_W-1:0]   cfg_data,
    hmcs_in_if.sink                      in_ch,
    output logic                         push_valid,
    output logic [JOB_W-1:0]             push_data,
    input  logic                         push_ready
);
    import hmcs_pkg::*;

    localparam int HB   = HEIGHT_BITS;
    localparam int EW   = HEIGHT_BITS + 1;
    localparam int CMPW = (CFG_W > CW + 1) ? CFG_W : CW + 1;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        logic [HB-1:0] height;
        logic [HB-1:0] num;
        logic [HB-1:0] span;
        logic          flat;
        logic          last;
    } job_t;

    logic [CFG_W-1:0]     map_width_reg;
    logic [CFG_W-1:0]     map_rows_reg;
    logic signed [HB-1:0] low_mark_reg;
    logic signed [HB-1:0] high_mark_reg;
    logic                 marks_valid_reg;
    logic                 converting_reg;
    logic [CW-1:0]        col_count_reg;
    logic [CW-1:0]        row_count_reg;

    logic                 accept;
    logic                 is_scan;
    logic signed [EW-1:0] h_ext;
    logic signed [EW-1:0] low_ext;
    logic signed [EW-1:0] span_ext;
    logic signed [EW-1:0] diff;
    logic [HB-1:0]        num;
    logic [CMPW-1:0]      w_lim;
    logic [CMPW-1:0]      r_lim;
    logic                 col_wrap;
    logic                 row_wrap;
    job_t                 job;

    // handshake
    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign is_scan     = (in_ch.req_type == REQ_SCAN);
    assign push_valid  = accept && !is_scan;

    // clamp raster dimensions to 1..MAX_DIM
    always_comb
    begin
        if (map_width_reg == '0)
            w_lim = CMPW'(1);
        else if (CMPW'(map_width_reg) > CMPW'(MAX_DIM))
            w_lim = CMPW'(MAX_DIM);
        else
            w_lim = CMPW'(map_width_reg);

        if (map_rows_reg == '0)
            r_lim = CMPW'(1);
        else if (CMPW'(map_rows_reg) > CMPW'(MAX_DIM))
            r_lim = CMPW'(MAX_DIM);
        else
            r_lim = CMPW'(map_rows_reg);
    end

    assign col_wrap = (CMPW'(col_count_reg) + CMPW'(1)) >= w_lim;
    assign row_wrap = (CMPW'(row_count_reg) + CMPW'(1)) >= r_lim;

    // offset from low mark, clamped into 0..span
    always_comb
    begin
        h_ext    = {in_ch.height_sample[HB-1], in_ch.height_sample};
        low_ext  = {low_mark_reg[HB-1], low_mark_reg};
        span_ext = {high_mark_reg[HB-1], high_mark_reg} - low_ext;
        diff     = h_ext - low_ext;
        if (diff[EW-1])
            num = '0;
        else if (diff > span_ext)
            num = span_ext[HB-1:0];
        else
            num = diff[HB-1:0];
    end

    // job for the divide back end
    always_comb
    begin
        job.col    = col_count_reg;
        job.row    = row_count_reg;
        job.height = in_ch.height_sample;
        job.num    = num;
        job.span   = span_ext[HB-1:0];
        job.flat   = (high_mark_reg == low_mark_reg);
        job.last   = col_wrap && row_wrap;
    end

    assign push_data = job;

    // configuration and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg   <= MAP_WIDTH_RST;
            map_rows_reg    <= MAP_ROWS_RST;
            low_mark_reg    <= '0;
            high_mark_reg   <= '0;
            marks_valid_reg <= 1'b0;
            converting_reg  <= 1'b0;
            col_count_reg   <= '0;
            row_count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH: map_width_reg <= cfg_data;
                    CFG_MAP_ROWS:  map_rows_reg  <= cfg_data;
                    default:       ;
                endcase
            end

            if (accept)
            begin
                if (is_scan)
                begin
                    // restart marks on the first scan of a pass
                    if (!marks_valid_reg || converting_reg)
                    begin
                        low_mark_reg    <= in_ch.height_sample;
                        high_mark_reg   <= in_ch.height_sample;
                        marks_valid_reg <= 1'b1;
                        converting_reg  <= 1'b0;
                        col_count_reg   <= '0;
                        row_count_reg   <= '0;
                    end
                    else
                    begin
                        if (in_ch.height_sample < low_mark_reg)
                            low_mark_reg <= in_ch.height_sample;
                        if (in_ch.height_sample > high_mark_reg)
                            high_mark_reg <= in_ch.height_sample;
                    end
                end
                else
                begin
                    converting_reg <= 1'b1;
                    if (col_wrap)
                    begin
                        col_count_reg <= '0;
                        if (row_wrap)
                            row_count_reg <= '0;
                        else
                            row_count_reg <= row_count_reg + CW'(1);
                    end
                    else
                    begin
                        col_count_reg <= col_count_reg + CW'(1);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/hmcs_queue.sv */
// ----------------------------------------------------------------------------
// hmcs_queue
// short fifo of divide jobs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module hmcs_queue #(
    parameter int W = 70
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [W-1:0]                 push_data,
    input  logic                         pop,
    output logic [W-1:0]                 pop_data,
    output hmcs_pkg::hmcs_queue_status_t status
);
    import hmcs_pkg::*;

    logic [W-1:0]      mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // status
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign status.level = count_reg;
    assign pop_data     = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* rtl/hmcs_back.sv */
// ----------------------------------------------------------------------------
// hmcs_back
// radix-2 divider for the red level and the vertex output register
// ----------------------------------------------------------------------------
`default_nettype none

module hmcs_back #(
    parameter int HEIGHT_BITS = 16,
    parameter int CW          = 10,
    parameter int JOB_W       = 2 * 10 + 3 * 16 + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [JOB_W-1:0]              job_data,
    input  hmcs_pkg::hmcs_queue_status_t  q_status,
    output hmcs_pkg::hmcs_back_status_t   status,
    hmcs_out_if.source                    out_ch
);
    import hmcs_pkg::*;

    localparam int HB = HEIGHT_BITS;
    localparam int DW = HEIGHT_BITS + RED_W;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        logic [HB-1:0] height;
        logic [HB-1:0] num;
        logic [HB-1:0] span;
        logic          flat;
        logic          last;
    } job_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [2:0]           step_reg;
    logic [HB-1:0]        rem_reg;
    logic [RED_W-1:0]     dlow_reg;
    logic [RED_W-1:0]     quo_reg;
    logic [HB-1:0]        span_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        row_reg;
    logic [HB-1:0]        height_reg;
    logic                 flat_reg;
    logic                 last_reg;
    logic                 out_valid_reg;
    logic [CW-1:0]        out_x_reg;
    logic [CW-1:0]        out_y_reg;
    logic [HB-1:0]        out_h_reg;
    logic [RED_W-1:0]     out_red_reg;
    logic                 out_flat_reg;
    logic                 out_last_reg;

    job_t                 job;
    logic                 pop;
    logic                 load;
    logic [DW-1:0]        dividend;
    logic [HB:0]          trial;
    logic                 fits;
    logic [HB:0]          diff;
    logic [RED_W-1:0]     red;

    assign job = job_data;
    assign pop = (state_reg == S_IDLE) && !q_status.empty;

    // load when the output register is free or draining
    assign load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    assign status.busy = (state_reg != S_IDLE);
    assign status.pop  = pop;

    // 255 * num as a shift and subtract
    assign dividend = {job.num, {RED_W{1'b0}}} - {{RED_W{1'b0}}, job.num};

    // one restoring divide step
    assign trial = {rem_reg, dlow_reg[RED_W-1]};
    assign diff  = trial - {1'b0, span_reg};
    assign fits  = !diff[HB];
    assign red   = flat_reg ? '0 : quo_reg;

    // outputs
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.vert_x      = out_x_reg;
    assign out_ch.vert_y      = out_y_reg;
    assign out_ch.vert_height = out_h_reg;
    assign out_ch.red_level   = out_red_reg;
    assign out_ch.green_level = out_red_reg[RED_W-1:1];
    assign out_ch.flat_error  = out_flat_reg;
    assign out_ch.frame_last  = out_last_reg;

    // sequencer, divider and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            rem_reg       <= '0;
            dlow_reg      <= '0;
            quo_reg       <= '0;
            span_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            height_reg    <= '0;
            flat_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_h_reg     <= '0;
            out_red_reg   <= '0;
            out_flat_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // output valid: set on load, cleared when taken
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        rem_reg    <= dividend[DW-1:RED_W];
                        dlow_reg   <= dividend[RED_W-1:0];
                        quo_reg    <= '0;
                        span_reg   <= job.span;
                        col_reg    <= job.col;
                        row_reg    <= job.row;
                        height_reg <= job.height;
                        flat_reg   <= job.flat;
                        last_reg   <= job.last;
                        step_reg   <= '0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= fits ? diff[HB-1:0] : trial[HB-1:0];
                    quo_reg  <= {quo_reg[RED_W-2:0], fits};
                    dlow_reg <= {dlow_reg[RED_W-2:0], 1'b0};
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (load)
                    begin
                        out_x_reg    <= col_reg;
                        out_y_reg    <= row_reg;
                        out_h_reg    <= height_reg;
                        out_red_reg  <= red;
                        out_flat_reg <= flat_reg;
                        out_last_reg <= last_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/heightmap_minmax_color_stretch.sv */
// ----------------------------------------------------------------------------
// heightmap_minmax_color_stretch
// min/max contrast stretch of raster heights into colored vertices
// ----------------------------------------------------------------------------
// Scan items (req_type 0) update the running min/max and are accepted while
// the job queue has room. Convert items (req_type 1) each produce one vertex:
// the back end pops a job, runs eight radix-2 restoring steps for the 8-bit
// red quotient in its divider, and then loads the output register. A
// two-entry job queue between the front end and the divider lets up to two
// converts be accepted ahead of the divider, and the output register holds
// a finished vertex while the next division runs. The user must write
// map_width and map_rows only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_minmax_color_stretch #(
    parameter int MAX_DIM     = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hmcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hmcs_pkg::CFG_W-1:0]     cfg_data,
    hmcs_in_if.sink                        in_ch,
    hmcs_out_if.source                     out_ch
);
    import hmcs_pkg::*;

`include "heightmap_minmax_color_stretch_macros.svh"

    localparam int CW    = $clog2(MAX_DIM);
    localparam int JOB_W = 2 * CW + 3 * HEIGHT_BITS + 2;

    logic               push_valid;
    logic [JOB_W-1:0]   push_data;
    logic [JOB_W-1:0]   pop_data;
    hmcs_queue_status_t q_status;
    hmcs_back_status_t  b_status;

    // front end: marks, counters, job build
    hmcs_front #(
        .MAX_DIM     (MAX_DIM),
        .HEIGHT_BITS (HEIGHT_BITS),
        .CW          (CW),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (!q_status.full)
    );

    // job queue
    hmcs_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (b_status.pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // back end: divider and output register
    hmcs_back #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .CW          (CW),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_data (pop_data),
        .q_status (q_status),
        .status   (b_status),
        .out_ch   (out_ch)
    );

    // checks
    `HMCS_ASSERT_NEXT(a_convert_queued, in_ch.valid && in_ch.ready && in_ch.req_type == REQ_CONVERT, !q_status.empty || b_status.busy, "convert transaction lost before the divider")
    `HMCS_ASSERT_IMP(a_pop_not_empty, b_status.pop, !q_status.empty, "divider popped an empty queue")
    `HMCS_ASSERT_IMP(a_out_after_div, $rose(out_ch.valid), $past(b_status.busy), "vertex shown without a division")

endmodule

`default_nettype wire

/* bench/heightmap_minmax_color_stretch_test.sv */
// ----------------------------------------------------------------------------
// heightmap_minmax_color_stretch_test
// self-checking bench for the height map min/max color stretch
// ----------------------------------------------------------------------------
// Sends scan and convert samples on the input channel with random gaps and
// takes vertices from the output channel with random stalls. A scoreboard
// keeps its own copy of the marks, raster counters and dimension registers.
// For every accepted convert it predicts one vertex, and it compares each
// vertex that arrives, field by field, against the oldest prediction. The
// run starts with a short directed part and then goes through random
// phases: mostly well-formed scan/convert frames, some convert-only
// continuations and some mixed noise. The map dimensions are rewritten
// between phases, including the zero and over-range values.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_minmax_color_stretch_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hmcs_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int HEIGHT_BITS  = 16;
    localparam int COORD_W      = 10;
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 24;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic [COORD_W-1:0]            vert_x;
        logic [COORD_W-1:0]            vert_y;
        logic signed [HEIGHT_BITS-1:0] vert_height;
        logic [RED_W-1:0]              red_level;
        logic [GREEN_W-1:0]            green_level;
        logic                          flat_error;
        logic                          frame_last;
    } vertex_t;

    // prediction of the stretch and store of pending vertices
    class stretch_scoreboard;
        vertex_t          expected_vertices[$];
        int               errors;
        int               low_mark;
        int               high_mark;
        bit               marks_valid;
        bit               converting;
        int               col_count;
        int               row_count;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] rows_reg;

        function new();
            errors      = 0;
            low_mark    = 0;
            high_mark   = 0;
            marks_valid = 1'b0;
            converting  = 1'b0;
            col_count   = 0;
            row_count   = 0;
            width_reg   = MAP_WIDTH_RST;
            rows_reg    = MAP_ROWS_RST;
        endfunction

        // zero acts as one, over-range acts as the maximum
        function int dim_limit(logic [CFG_W-1:0] v);
            if (v == '0)
                return 1;
            if (int'(v) > MAX_DIM)
                return MAX_DIM;
            return int'(v);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_MAP_WIDTH)
                width_reg = val;
            else if (idx == CFG_MAP_ROWS)
                rows_reg = val;
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction

        // one accepted input transaction
        function void note_sample(logic req, logic signed [HEIGHT_BITS-1:0] h);
            int      hv;
            int      span;
            int      num;
            int      red;
            int      w;
            int      r;
            vertex_t v;
            hv = h;
            w  = dim_limit(width_reg);
            r  = dim_limit(rows_reg);

            // scan: restart or widen the marks
            if (req == REQ_SCAN)
            begin
                if (!marks_valid || converting)
                begin
                    low_mark    = hv;
                    high_mark   = hv;
                    marks_valid = 1'b1;
                    converting  = 1'b0;
                    col_count   = 0;
                    row_count   = 0;
                end
                else
                begin
                    if (hv < low_mark)
                        low_mark = hv;
                    if (hv > high_mark)
                        high_mark = hv;
                end
                return;
            end

            // convert: stretch into the color levels, clamped to the marks
            converting = 1'b1;
            red        = 0;
            v          = '0;
            if (high_mark == low_mark)
            begin
                v.flat_error = 1'b1;
            end
            else
            begin
                span = high_mark - low_mark;
                num  = hv - low_mark;
                if (num < 0)
                    num = 0;
                if (num > span)
                    num = span;
                red = (255 * num) / span;
            end
            v.vert_x      = COORD_W'(col_count);
            v.vert_y      = COORD_W'(row_count);
            v.vert_height = h;
            v.red_level   = RED_W'(red);
            v.green_level = GREEN_W'(red >> 1);

            // raster counters, wrap also when at or past a lowered limit
            if (col_count + 1 >= w)
            begin
                col_count = 0;
                if (row_count + 1 >= r)
                begin
                    row_count    = 0;
                    v.frame_last = 1'b1;
                end
                else
                begin
                    row_count++;
                end
            end
            else
            begin
                col_count++;
            end
            expected_vertices = {expected_vertices, v};
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // one accepted output transaction
        function void check_vertex(vertex_t got);
            vertex_t want;
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: vertex expected none actual x=%0d y=%0d h=%0d",
                         $time, got.vert_x, got.vert_y, got.vert_height);
                errors++;
                return;
            end
            want = expected_vertices.pop_front();
            compare_field("vert_x", want.vert_x, got.vert_x);
            compare_field("vert_y", want.vert_y, got.vert_y);
            compare_field("vert_height", want.vert_height, got.vert_height);
            compare_field("red_level", want.red_level, got.red_level);
            compare_field("green_level", want.green_level, got.green_level);
            compare_field("flat_error", want.flat_error, got.flat_error);
            compare_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    hmcs_in_if  #(.HEIGHT_BITS(HEIGHT_BITS)) in_ch ();
    hmcs_out_if #(.HEIGHT_BITS(HEIGHT_BITS), .COORD_W(COORD_W)) out_ch ();

    heightmap_minmax_color_stretch #(
        .MAX_DIM     (MAX_DIM),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    stretch_scoreboard board;
    bit                calm;
    int                item_count;
    int                height_base;
    int                height_spread;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("heightmap_minmax_color_stretch: mismatch");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_height();
        return height_base + int'($urandom_range(0, height_spread));
    endfunction

    // pick a height band: flat, two values, narrow or full range
    task automatic pick_band();
        int roll;
        roll        = $urandom_range(0, 9);
        height_base = int'($urandom_range(0, 65535)) - 32768;
        if (roll < 2)
            height_spread = 0;
        else if (roll < 3)
            height_spread = 1;
        else if (roll < 6)
            height_spread = $urandom_range(2, 255);
        else
            height_spread = 65535;
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll == 2)
            return CFG_W'(MAX_DIM);
        if (roll == 3)
            return CFG_W'(1);
        if (roll == 4)
            return CFG_W'($urandom_range(0, 2047));
        return CFG_W'($urandom_range(1, 6));
    endfunction

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_sample(in_ch.req_type, in_ch.height_sample);
    end

    // output monitor
    always @(posedge clk)
    begin
        vertex_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.vert_x      = out_ch.vert_x;
            got.vert_y      = out_ch.vert_y;
            got.vert_height = out_ch.vert_height;
            got.red_level   = out_ch.red_level;
            got.green_level = out_ch.green_level;
            got.flat_error  = out_ch.flat_error;
            got.frame_last  = out_ch.frame_last;
            board.check_vertex(got);
        end
    end

    // receiver stalls
    initial
    begin
        int stall;
        int run;
        out_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = gap_len();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge clk);
        end
    end

    // one input transaction, valid stays high for a back-to-back follower
    task automatic send_item(logic req, int hgt);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= req;
        in_ch.height_sample <= HEIGHT_BITS'(hgt);
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        item_count++;
    endtask

    // wait for every pending vertex and let trailing scans settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int target;
        int n;
        int m;
        int kind;
        int frame;
        int phase;
        board               = new();
        calm                = 1'b0;
        item_count          = 0;
        height_base         = 0;
        height_spread       = 0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_MAP_WIDTH;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.req_type      <= REQ_SCAN;
        in_ch.height_sample <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // convert before any scan: flat
        send_item(REQ_CONVERT, 5);
        // full-range marks, restart after a convert
        send_item(REQ_SCAN, -32768);
        send_item(REQ_SCAN, 32767);
        send_item(REQ_SCAN, 0);
        send_item(REQ_CONVERT, 32767);
        send_item(REQ_CONVERT, -32768);
        send_item(REQ_CONVERT, 0);
        send_item(REQ_CONVERT, 1);
        send_item(REQ_CONVERT, -1);
        wait_drained();
        write_register(CFG_MAP_WIDTH, CFG_W'(3));
        write_register(CFG_MAP_ROWS, CFG_W'(2));
        // flat map
        send_item(REQ_SCAN, 100);
        send_item(REQ_SCAN, 100);
        send_item(REQ_CONVERT, 100);
        send_item(REQ_CONVERT, 100);
        // heights outside the marks, full 3x2 frame and a new pass after it
        send_item(REQ_SCAN, 0);
        send_item(REQ_SCAN, 10);
        send_item(REQ_CONVERT, -5);
        send_item(REQ_CONVERT, 20);
        send_item(REQ_CONVERT, 5);
        send_item(REQ_CONVERT, 10);
        send_item(REQ_CONVERT, 0);
        send_item(REQ_CONVERT, 3);
        send_item(REQ_CONVERT, 7);
        // scan cutting into a convert pass
        send_item(REQ_SCAN, 50);
        send_item(REQ_CONVERT, 50);
        // zero and over-range dimensions
        wait_drained();
        write_register(CFG_MAP_WIDTH, '0);
        write_register(CFG_MAP_ROWS, '1);
        send_item(REQ_CONVERT, -20000);
        send_item(REQ_CONVERT, 20000);
        wait_drained();
        write_register(CFG_MAP_WIDTH, '1);
        write_register(CFG_MAP_ROWS, '0);
        send_item(REQ_CONVERT, 12345);

        // random phases
        target = item_count + RANDOM_ITEMS;
        phase  = 0;
        while (item_count < target)
        begin
            // idle points: reconfigure, or just let everything drain
            if (phase == 0 || $urandom_range(0, 3) == 0)
            begin
                wait_drained();
                write_register(CFG_MAP_WIDTH, pick_dim());
                write_register(CFG_MAP_ROWS, pick_dim());
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
            end
            calm = ($urandom_range(0, 4) == 0);
            pick_band();
            kind  = $urandom_range(0, 9);
            frame = board.dim_limit(board.width_reg) * board.dim_limit(board.rows_reg);
            if (kind < 8)
            begin
                // well-formed frame: scans then converts
                n = $urandom_range(1, 12);
                repeat (n) send_item(REQ_SCAN, pick_height());
                if (frame <= 40 && $urandom_range(0, 1) == 1)
                    m = frame + $urandom_range(0, 2);
                else
                    m = $urandom_range(1, 24);
                repeat (m) send_item(REQ_CONVERT, pick_height());
            end
            else if (kind == 8)
            begin
                // continue the current pass with the old marks
                m = $urandom_range(1, 10);
                repeat (m) send_item(REQ_CONVERT, pick_height());
            end
            else
            begin
                // noise: mixed transaction types
                n = $urandom_range(1, 16);
                repeat (n) send_item(logic'($urandom_range(0, 1)), pick_height());
            end
            phase++;
        end
        calm = 1'b0;

        // wait for the tail
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("heightmap_minmax_color_stretch: match");
        else
            $display("heightmap_minmax_color_stretch: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

/* heightmap_minmax_color_stretch.f */
+incdir+rtl
rtl/hmcs_pkg.sv
rtl/hmcs_if.sv
rtl/hmcs_front.sv
rtl/hmcs_queue.sv
rtl/hmcs_back.sv
rtl/heightmap_minmax_color_stretch.sv
bench/heightmap_minmax_color_stretch_test.sv
